// File: hw/rtl/sixcd_pkg.sv
// ============================================================================
// sixcd_pkg
// Shared widths, register indexes and reset values of the six channel clock
// divider with swing.
// ============================================================================
package sixcd_pkg;

    // Defaults of the top level parameters
    localparam int DEF_CHANNELS      = 6;
    localparam int DEF_COUNTER_WIDTH = 24;
    localparam int DEF_MAX_DIVISION  = 16;

    // Fixed field widths
    localparam int GATE_W     = 6;
    localparam int LEVEL_W    = 11;
    localparam int DIV_IN_W   = 5;
    localparam int PERIOD_W   = 24;
    localparam int SWING_W    = 16;
    localparam int EDGE_W     = 20;
    localparam int REM_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Level scale: 1024 means 1.0
    localparam int                  LEVEL_SHIFT = 10;
    localparam logic [LEVEL_W-1:0]  LEVEL_ONE   = 11'd1024;
    localparam logic [LEVEL_W-1:0]  WIDTH_BIAS  = 11'd256;

    // Edge count wraps at lcm(1..16)
    localparam logic [EDGE_W-1:0]   EDGE_WRAP   = 20'd720720;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = {PERIOD_W{1'b1}};
    localparam logic [REM_W-1:0]    FIVE        = 4'd5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWING_MAX      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_PERIOD    = 2'd2;

    // Configuration reset values
    localparam logic [GATE_W-1:0]   ENABLE_RST      = 6'h3F;
    localparam logic [SWING_W-1:0]  SWING_MAX_RST   = 16'd4800;
    localparam logic [PERIOD_W-1:0] INIT_PERIOD_RST = 24'd48000;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        clamp_level = (v > LEVEL_ONE) ? LEVEL_ONE : v;
    endfunction

endpackage

// File: hw/rtl/sixcd_ram.sv
// ============================================================================
// sixcd_ram
// Generic single write port RAM with one registered read port.
// ============================================================================
module sixcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 6,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/six_channel_clock_divider_swing_unit.sv
// ============================================================================
// six_channel_clock_divider_swing_unit
// Six channel clock divider: measures the clock period, counts edges and
// drives one gate per channel with width and swing control.
// ============================================================================
//
//  port group      direction  handshake          payload
//  --------------  ---------  -----------------  ------------------------------
//  tick in         in         i_valid / o_ready  bang, reset, width, swing,
//                                                div_one .. div_six
//  result out      out        o_valid / i_ready  o_gates, o_measured_period
//  config write    in         i_cfg_we           i_cfg_addr, i_cfg_wdata
//
//  One tick beat runs from accept to result valid through the shared
//  arithmetic states S_CTRL to S_PW (counters, period multiply, reciprocal
//  divide by five, remainder fix-up), then one pass through the since-pulse
//  RAM at one channel per cycle, then S_DRAIN and the load in S_DONE.
//  A new tick is taken only back in S_IDLE, after the result is loaded.
//  Reset is synchronous and ends at once: per entry valid bits stand in for
//  the zeroed since-pulse counters, no clearing pass.
//  A waiting result does not block the next tick: o_ready rises again as soon
//  as the result register is loaded; only a second finished result waits for
//  i_ready before it is written.
//
module six_channel_clock_divider_swing_unit #(
    parameter int CHANNELS      = sixcd_pkg::DEF_CHANNELS,
    parameter int COUNTER_WIDTH = sixcd_pkg::DEF_COUNTER_WIDTH,
    parameter int MAX_DIVISION  = sixcd_pkg::DEF_MAX_DIVISION
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // tick in
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_bang_level,
    input  logic                                i_reset_level,
    input  logic [sixcd_pkg::LEVEL_W-1:0]       i_width_level,
    input  logic [sixcd_pkg::LEVEL_W-1:0]       i_swing_level,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_one,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_two,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_three,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_four,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_five,
    input  logic [sixcd_pkg::DIV_IN_W-1:0]      i_div_six,

    // result out
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sixcd_pkg::GATE_W-1:0]        o_gates,
    output logic [sixcd_pkg::PERIOD_W-1:0]      o_measured_period,

    // config write
    input  logic                                i_cfg_we,
    input  logic [sixcd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sixcd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import sixcd_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    localparam int CW    = COUNTER_WIDTH;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // period path is at least as wide as the period output
    localparam int P_W   = (CW > PERIOD_W) ? CW : PERIOD_W;
    localparam int PW_W  = P_W - 2;            // pulse width <= period / 4
    localparam int MP_W  = P_W + LEVEL_W;      // period * (256 + width)
    localparam int X_W   = P_W + 1;            // that product >> 10
    localparam int RS    = P_W + 3;            // reciprocal shift, 2^RS > x
    localparam int K_W   = RS - 2;
    localparam int QP_W  = X_W + K_W;
    localparam int SP_W  = LEVEL_W + SWING_W;
    localparam int DIV_W = $clog2(MAX_DIVISION + 1);
    localparam int RES_W = $clog2(MAX_DIVISION);
    localparam int PD_W  = PW_W + DIV_W;
    localparam int THR_W = P_W + 4;

    localparam logic [63:0]   RECIP_FULL = (64'd1 << RS) / 64'd5;
    localparam logic [K_W-1:0] RECIP     = RECIP_FULL[K_W-1:0];
    localparam logic [CW-1:0] CNT_MAX    = {CW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CTRL,
        S_MUL,
        S_RECIP,
        S_REM,
        S_PW,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_IN_W-1:0] d);
        if (d == '0) begin
            clamp_div = DIV_W'(1);
        end else if (int'(d) > MAX_DIVISION) begin
            clamp_div = DIV_W'(MAX_DIVISION);
        end else begin
            clamp_div = DIV_W'(d);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state              r_state;

    // configuration
    logic [GATE_W-1:0]   r_chan_en;
    logic [SWING_W-1:0]  r_swing_max;

    // block state outside the RAM
    logic [CW-1:0]       r_tsc;            // ticks since clock
    logic [P_W-1:0]      r_period;
    logic [EDGE_W-1:0]   r_edge;
    logic [RES_W-1:0]    r_res [0:MAX_DIVISION-1];  // edge count mod (i + 1)
    logic                r_prev_bang;
    logic                r_prev_rst;
    logic                r_bang_rise;
    logic [GATE_W-1:0]   r_gate;
    logic [CHANNELS-1:0] r_tsp_vld;        // since-pulse entry written since reset

    // latched tick
    logic                r_bang;
    logic                r_rst_lvl;
    logic [LEVEL_W-1:0]  r_width;
    logic [LEVEL_W-1:0]  r_swl;
    logic [DIV_W-1:0]    r_div [0:GATE_W-1];

    // shared arithmetic
    logic [MP_W-1:0]     r_prod;
    logic [SWING_W-1:0]  r_swing;
    logic [QP_W-1:0]     r_qprod;
    logic [PW_W-1:0]     r_q0;
    logic [REM_W-1:0]    r_rem;
    logic [PW_W-1:0]     r_pw;

    // channel pass: stage A reads, stage B updates and writes back
    logic [CH_W-1:0]     r_ch_a;
    logic                r_b_valid;
    logic [CH_W-1:0]     r_ch_b;
    logic [THR_W-1:0]    r_thr_b;
    logic                r_resz_b;
    logic                r_vld_b;
    logic                r_in_win;

    // result
    logic                r_out_valid;
    logic [GATE_W-1:0]   r_out_gates;
    logic [PERIOD_W-1:0] r_out_period;

    // ------------------------------------------------------------------------
    // Counter and edge update (S_CTRL)
    // A rising reset level loads edge count 1 before the clock edge is taken.
    // ------------------------------------------------------------------------
    logic                rst_rise;
    logic                bang_rise;
    logic [EDGE_W-1:0]   edge_mid;
    logic [EDGE_W-1:0]   n_edge;
    logic [RES_W-1:0]    res_mid [0:MAX_DIVISION-1];
    logic [RES_W-1:0]    n_res   [0:MAX_DIVISION-1];
    logic [CW-1:0]       tsc_inc;

    always_comb begin
        rst_rise  = r_rst_lvl && !r_prev_rst;
        bang_rise = r_bang && !r_prev_bang;
        edge_mid  = rst_rise ? EDGE_W'(1) : r_edge;
        n_edge    = edge_mid;
        if (bang_rise) begin
            n_edge = (edge_mid == EDGE_WRAP - EDGE_W'(1)) ? '0 : edge_mid + EDGE_W'(1);
        end
        for (int i = 0; i < MAX_DIVISION; i++) begin
            // divisor i + 1; divisor one always has residue zero
            res_mid[i] = rst_rise ? ((i == 0) ? '0 : RES_W'(1)) : r_res[i];
            n_res[i]   = res_mid[i];
            if (bang_rise) begin
                n_res[i] = (res_mid[i] == RES_W'(i)) ? '0 : res_mid[i] + RES_W'(1);
            end
        end
        tsc_inc = (r_tsc == CNT_MAX) ? r_tsc : r_tsc + CW'(1);
    end

    // ------------------------------------------------------------------------
    // Shared arithmetic
    // pw = floor(period * (256 + width) / 5120): the product is shifted by 10,
    // then divided by five through a reciprocal multiply that lands on the
    // quotient or one below it, fixed up from the remainder.
    // ------------------------------------------------------------------------
    logic [SP_W-1:0]     sprod;
    logic [X_W-1:0]      x_val;
    logic [PW_W-1:0]     q0;
    logic [X_W-1:0]      five_q0;
    logic [X_W-1:0]      rem_full;

    assign sprod    = SP_W'(r_swl) * SP_W'(r_swing_max);
    assign x_val    = r_prod[LEVEL_SHIFT +: X_W];
    assign q0       = r_qprod[RS +: PW_W];
    assign five_q0  = (X_W'(q0) << 2) + X_W'(q0);
    assign rem_full = x_val - five_q0;

    // ------------------------------------------------------------------------
    // Channel pass, stage A: select division, residue and threshold
    // ------------------------------------------------------------------------
    logic [DIV_W-1:0]    d_sel;
    logic [RES_W-1:0]    res_sel;
    logic [PD_W-1:0]     pw_div;
    logic [THR_W-1:0]    win_hi;
    logic                in_win;

    always_comb begin
        d_sel = DIV_W'(1);   // channels without a division input divide by one
        for (int g = 0; g < GATE_W; g++) begin
            if (g < CHANNELS && r_ch_a == CH_W'(g)) begin
                d_sel = r_div[g];
            end
        end
        res_sel = r_res[RES_W'(d_sel - DIV_W'(1))];
        pw_div  = PD_W'(r_pw) * PD_W'(d_sel);
        win_hi  = THR_W'(r_pw) + THR_W'(r_swing);
        in_win  = (THR_W'(r_tsc) > THR_W'(r_swing)) && (THR_W'(r_tsc) < win_hi);
    end

    // ------------------------------------------------------------------------
    // Channel pass, stage B: since-pulse update and gate decision
    // Each entry is read and written once per tick and ticks never overlap,
    // so read-after-write needs no forwarding.
    // ------------------------------------------------------------------------
    logic [CW-1:0]       ram_rdata;
    logic [CW-1:0]       tsp_base;
    logic [CW-1:0]       tsp_inc;
    logic [CW-1:0]       tsp_new;
    logic                tsp_over;
    logic [GATE_W-1:0]   n_gate;

    always_comb begin
        tsp_base = r_vld_b ? ram_rdata : '0;
        tsp_inc  = (tsp_base == CNT_MAX) ? tsp_base : tsp_base + CW'(1);
        tsp_new  = (r_bang_rise && r_resz_b) ? '0 : tsp_inc;
        tsp_over = THR_W'(tsp_new) > r_thr_b;
        n_gate   = r_gate;
        for (int g = 0; g < GATE_W; g++) begin
            if (g < CHANNELS && r_ch_b == CH_W'(g)) begin
                if (!r_chan_en[g]) begin
                    n_gate[g] = 1'b0;
                end else if (r_in_win) begin
                    if (r_resz_b) begin
                        n_gate[g] = 1'b1;
                    end
                end else if (tsp_over) begin
                    n_gate[g] = 1'b0;
                end
            end
        end
    end

    sixcd_ram #(
        .WIDTH (CW),
        .DEPTH (CHANNELS)
    ) u_tsp_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_ch_b),
        .i_wdata (tsp_new),
        .i_raddr (r_ch_a),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Control: sequencer, block state, configuration, result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan_en   <= ENABLE_RST;
            r_swing_max <= SWING_MAX_RST;
            r_tsc       <= '0;
            r_period    <= P_W'(INIT_PERIOD_RST);
            r_edge      <= '0;
            for (int i = 0; i < MAX_DIVISION; i++) begin
                r_res[i] <= '0;
            end
            r_prev_bang <= 1'b0;
            r_prev_rst  <= 1'b0;
            r_bang_rise <= 1'b0;
            r_gate      <= '0;
            r_tsp_vld   <= '0;
            r_ch_a      <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the done state handles its own result register update
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            r_b_valid <= (r_state == S_SCAN);
            if (r_b_valid) begin
                r_gate            <= n_gate;
                r_tsp_vld[r_ch_b] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CTRL;
                    end
                end
                S_CTRL: begin
                    r_tsc       <= bang_rise ? '0 : tsc_inc;
                    if (bang_rise) begin
                        r_period <= P_W'(tsc_inc);
                    end
                    r_edge      <= n_edge;
                    r_res       <= n_res;
                    r_prev_bang <= r_bang;
                    r_prev_rst  <= r_rst_lvl;
                    r_bang_rise <= bang_rise;
                    r_state     <= S_MUL;
                end
                S_MUL:   r_state <= S_RECIP;
                S_RECIP: r_state <= S_REM;
                S_REM:   r_state <= S_PW;
                S_PW: begin
                    r_ch_a  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_ch_a == CH_W'(CHANNELS - 1)) begin
                        r_ch_a  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_ch_a <= r_ch_a + CH_W'(1);
                    end
                end
                S_DRAIN: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_gates  <= r_gate;
                        r_out_period <= (r_period > P_W'(PERIOD_MAX)) ?
                                        PERIOD_MAX : r_period[PERIOD_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // config writes must come only while idle; the block does not enforce this
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CHANNEL_ENABLE: r_chan_en   <= i_cfg_wdata[GATE_W-1:0];
                    CFG_SWING_MAX:      r_swing_max <= i_cfg_wdata[SWING_W-1:0];
                    CFG_INIT_PERIOD:    r_period    <= P_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_bang    <= i_bang_level;
            r_rst_lvl <= i_reset_level;
            r_width   <= clamp_level(i_width_level);
            r_swl     <= clamp_level(i_swing_level);
            r_div[0]  <= clamp_div(i_div_one);
            r_div[1]  <= clamp_div(i_div_two);
            r_div[2]  <= clamp_div(i_div_three);
            r_div[3]  <= clamp_div(i_div_four);
            r_div[4]  <= clamp_div(i_div_five);
            r_div[5]  <= clamp_div(i_div_six);
        end
        if (r_state == S_MUL) begin
            r_prod  <= MP_W'(r_period) * MP_W'(r_width + WIDTH_BIAS);
            // swing drops out on every fourth count
            r_swing <= (r_edge[1:0] == 2'b00) ? '0 : sprod[LEVEL_SHIFT +: SWING_W];
        end
        if (r_state == S_RECIP) begin
            r_qprod <= QP_W'(x_val) * QP_W'(RECIP);
        end
        if (r_state == S_REM) begin
            r_q0  <= q0;
            r_rem <= rem_full[REM_W-1:0];
        end
        if (r_state == S_PW) begin
            r_pw <= (r_rem >= FIVE) ? r_q0 + PW_W'(1) : r_q0;
        end
        if (r_state == S_SCAN) begin
            r_ch_b   <= r_ch_a;
            r_thr_b  <= THR_W'(pw_div) + THR_W'(r_swing);
            r_resz_b <= (res_sel == '0);
            r_vld_b  <= r_tsp_vld[r_ch_a];
            r_in_win <= in_win;
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_gates           = r_out_gates;
    assign o_measured_period = r_out_period;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_stage_b_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("stage B active outside the channel pass");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CTRL))
        else $error("accepted beat did not start the counter update");

    a_parity_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res[1] == RES_W'(r_edge[0]))
        else $error("residue mod two disagrees with edge count");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the six channel clock divider with swing. A short
// table of directed ticks, then clocked tick streams with random content
// under several register settings. Each result beat is checked against a
// typed-in value or a cycle-free predictor of the divider in the bench.
// ============================================================================
module tb;
    import sixcd_pkg::*;

    localparam int          CH              = DEF_CHANNELS;
    localparam int          MAX_DIV         = DEF_MAX_DIVISION;
    localparam int          PW_SCALE        = 5120;     // gate length = period * (256+w) / 5120
    localparam int          SWING_DROP      = 4;        // swing dropped when edges % SWING_DROP == 0
    localparam int          DIRECTED_ROWS   = 20;
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 222;
    localparam int          HOLD_OFF        = 400;      // long receiver stall, in cycles
    localparam int          HOLD_AFTER      = 300;      // results seen before the long stall
    localparam int          DRAIN_CYCLES    = 20;       // settle time at the end of the run
    localparam int unsigned LIMIT_CYCLES    = 1_000_000;

    // Index past the register list: writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                          bang;
        logic                          rst;
        logic [LEVEL_W-1:0]            width;
        logic [LEVEL_W-1:0]            swing;
        logic [CH-1:0][DIV_IN_W-1:0]   div;
    } t_tick;

    typedef struct packed {
        logic [GATE_W-1:0]   gates;
        logic [PERIOD_W-1:0] period;
    } t_gate_word;

    typedef struct {
        bit bang;
        bit rst;
        int width;
        int swing;
        int d1, d2, d3, d4, d5, d6;
        bit lit;            // expected result typed in below
        int lit_gates;
        int lit_period;
    } t_plan_row;

    typedef struct {
        int  enable;
        int  swing_max;
        int  period;
        bit  spare;         // also poke the unused index
    } t_cfg_phase;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_tick                 tick_bus;
    logic                  o_valid;
    logic                  i_ready;
    logic [GATE_W-1:0]     o_gates;
    logic [PERIOD_W-1:0]   o_measured_period;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    six_channel_clock_divider_swing_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_bang_level      (tick_bus.bang),
        .i_reset_level     (tick_bus.rst),
        .i_width_level     (tick_bus.width),
        .i_swing_level     (tick_bus.swing),
        .i_div_one         (tick_bus.div[0]),
        .i_div_two         (tick_bus.div[1]),
        .i_div_three       (tick_bus.div[2]),
        .i_div_four        (tick_bus.div[3]),
        .i_div_five        (tick_bus.div[4]),
        .i_div_six         (tick_bus.div[5]),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_gates           (o_gates),
        .o_measured_period (o_measured_period),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: registers and divider state as seen after each tick
    // ------------------------------------------------------------------------
    logic [GATE_W-1:0]   en_mask    = ENABLE_RST;
    logic [SWING_W-1:0]  swing_full = SWING_MAX_RST;
    logic [PERIOD_W-1:0] since_clock = '0;
    logic [PERIOD_W-1:0] since_pulse [CH];
    logic [EDGE_W-1:0]   edges       = '0;
    logic [PERIOD_W-1:0] period_now  = INIT_PERIOD_RST;
    logic                last_bang   = 1'b0;
    logic                last_reset  = 1'b0;
    logic [GATE_W-1:0]   gate_q      = '0;

    t_gate_word  gate_queue [$];    // expected result beats, oldest first
    int          errors       = 0;
    int          results_seen = 0;
    int unsigned cycle_count  = 0;

    // Tick stream generator state
    int      clk_len  = 0;
    int      clk_hi   = 0;
    int      clk_pos  = 0;
    int      rst_left = 0;
    int      div_set [CH];
    bit      calm_tx  = 1'b0;

    initial begin
        for (int c = 0; c < CH; c++) begin
            since_pulse[c] = '0;
            div_set[c]     = 1;
        end
    end

    // One tick of the divider. Updates the predictor state, returns the beat.
    function automatic t_gate_word predict_gates(t_tick t);
        logic [LEVEL_W-1:0] wl;
        logic [LEVEL_W-1:0] sl;
        int unsigned        dv [CH];
        longint unsigned    pw;
        longint unsigned    swing;
        longint unsigned    hi;
        t_gate_word         r;
        wl = (t.width > LEVEL_ONE) ? LEVEL_ONE : t.width;
        sl = (t.swing > LEVEL_ONE) ? LEVEL_ONE : t.swing;
        for (int c = 0; c < CH; c++) begin
            if (t.div[c] == 0)
                dv[c] = 1;
            else if (t.div[c] > MAX_DIV)
                dv[c] = MAX_DIV;
            else
                dv[c] = 32'(t.div[c]);
        end

        // saturating tick counters
        if (since_clock != PERIOD_MAX)
            since_clock = since_clock + 1'b1;
        for (int c = 0; c < CH; c++) begin
            if (since_pulse[c] != PERIOD_MAX)
                since_pulse[c] = since_pulse[c] + 1'b1;
        end

        // reset goes first, so a joint reset/clock edge lands on count two
        if (t.rst && !last_reset)
            edges = EDGE_W'(1);
        last_reset = t.rst;

        if (t.bang && !last_bang) begin
            edges = (edges == EDGE_WRAP - 1) ? '0 : edges + 1'b1;
            for (int c = 0; c < CH; c++) begin
                if (edges % dv[c] == 0)
                    since_pulse[c] = '0;
            end
            period_now  = since_clock;
            since_clock = '0;
        end
        last_bang = t.bang;

        pw    = (64'(period_now) * (64'(WIDTH_BIAS) + 64'(wl))) / PW_SCALE;
        swing = (edges % SWING_DROP == 0) ? 64'd0
                                          : (64'(sl) * 64'(swing_full)) >> LEVEL_SHIFT;
        hi    = pw + swing;

        for (int c = 0; c < CH; c++) begin
            if (!en_mask[c]) begin
                gate_q[c] = 1'b0;
            end else if (since_clock < hi && since_clock > swing) begin
                if (edges % dv[c] == 0)
                    gate_q[c] = 1'b1;
            end else if (since_pulse[c] > pw * dv[c] + swing) begin
                gate_q[c] = 1'b0;
            end
        end

        r.gates  = gate_q;
        r.period = period_now;
        return r;
    endfunction

    // Next tick of a clocked stream: square clock of random period, sparse
    // reset pulses, random levels, and a little noise on every input.
    function automatic t_tick make_tick();
        t_tick t;
        int    r;
        if (clk_pos == 0) begin
            r = $urandom_range(99);
            if (r < 10)      clk_len = $urandom_range(2, 4);
            else if (r < 75) clk_len = $urandom_range(8, 40);
            else             clk_len = $urandom_range(60, 120);
            clk_hi = $urandom_range(1, clk_len - 1);
            if ($urandom_range(99) < 3)
                rst_left = $urandom_range(1, 4);
            if ($urandom_range(99) < 4) begin
                for (int c = 0; c < CH; c++)
                    div_set[c] = ($urandom_range(9) == 0) ? $urandom_range(31)
                                                          : $urandom_range(1, 16);
            end
        end
        t.bang  = (clk_pos < clk_hi);
        clk_pos = (clk_pos + 1 >= clk_len) ? 0 : clk_pos + 1;
        if ($urandom_range(99) < 4)
            t.bang = 1'($urandom_range(1));

        t.rst = (rst_left > 0);
        if (rst_left > 0)
            rst_left--;
        if ($urandom_range(99) < 1)
            t.rst = ~t.rst;

        r = $urandom_range(99);
        if (r < 10)      t.width = (r < 4) ? 11'd0 : ((r < 8) ? LEVEL_ONE : 11'h7FF);
        else if (r < 25) t.width = LEVEL_W'($urandom_range(2047));
        else             t.width = LEVEL_W'($urandom_range(1024));
        r = $urandom_range(99);
        if (r < 15)      t.swing = (r < 8) ? 11'd0 : LEVEL_ONE;
        else if (r < 30) t.swing = LEVEL_W'($urandom_range(2047));
        else             t.swing = LEVEL_W'($urandom_range(1024));

        for (int c = 0; c < CH; c++)
            t.div[c] = DIV_IN_W'(div_set[c]);
        if ($urandom_range(99) < 3)
            t.div[$urandom_range(CH - 1)] = DIV_IN_W'($urandom_range(31));
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Tick sender. Starts and ends on a falling edge; valid holds until the
    // beat is taken, and the expectation is queued on the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_tick(input t_tick t, input bit use_lit, input t_gate_word lit_word);
        t_gate_word want;
        int         gap;
        int         r;
        if ($urandom_range(99) < 2)
            calm_tx = ~calm_tx;
        r   = $urandom_range(99);
        gap = 0;
        if (!calm_tx) begin
            if (r >= 90)      gap = $urandom_range(10, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        tick_bus = t;
        do @(posedge i_clk); while (!o_ready);
        want = predict_gates(t);
        gate_queue.push_back(use_lit ? lit_word : want);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data[CFG_DATA_W-1:0];
        case (addr)
            CFG_CHANNEL_ENABLE: en_mask    = data[GATE_W-1:0];
            CFG_SWING_MAX:      swing_full = data[SWING_W-1:0];
            CFG_INIT_PERIOD:    period_now = data[PERIOD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Block is idle once every expected beat is back
    task automatic wait_idle();
        i_valid = 1'b0;
        while (gate_queue.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed ticks under reset settings. Row 0: first tick after reset,
    // inside the window on edge count zero, so all gates open with the reset
    // period. Row 1: first clock edge two ticks in, period reads 2, gates
    // hold. The rest cover level and division clamps, reset alone, reset
    // with the clock, and the swing drop on edge counts divisible by SWING_DROP.
    // ------------------------------------------------------------------------
    t_plan_row plan [DIRECTED_ROWS] = '{
        '{0, 0,     0,     0,  1,  1,  1,  1,  1,  1, 1, 'h3F, 48000},
        '{1, 0,     0,     0,  1,  1,  1,  1,  1,  1, 1, 'h3F,     2},
        '{0, 0,  1024,  1024, 16, 16, 16, 16, 16, 16, 0, 0, 0},
        '{0, 0,  2047,  2047,  0, 31, 17, 16,  2,  3, 0, 0, 0},
        '{1, 0, 'h555, 'h2AA,  2,  3,  4,  5,  6,  7, 0, 0, 0},
        '{1, 0, 'h2AA, 'h555,  2,  3,  4,  5,  6,  7, 0, 0, 0},
        '{0, 0,  1024,     0,  2,  3,  4,  5,  6,  7, 0, 0, 0},
        '{0, 1,  1024,     0,  8,  9, 10, 11, 12, 13, 0, 0, 0},
        '{1, 1,  1024,     0,  8,  9, 10, 11, 12, 13, 0, 0, 0},
        '{0, 0,   512,   512,  1,  2,  3,  4,  5,  6, 0, 0, 0},
        '{1, 1,   512,   512,  1,  2,  3,  4,  5,  6, 0, 0, 0},
        '{0, 0,     0,     0,  1,  2,  3,  4,  5,  6, 0, 0, 0},
        '{1, 0,  1024,  1024,  1,  2,  4,  8, 16,  1, 0, 0, 0},
        '{0, 0,  1024,  1024,  1,  2,  4,  8, 16,  1, 0, 0, 0},
        '{1, 0,  1024,  1024,  1,  2,  4,  8, 16,  1, 0, 0, 0},
        '{0, 0,  1024,  1024,  1,  2,  4,  8, 16,  1, 0, 0, 0},
        '{0, 0,     0,     0,  0,  0,  0,  0,  0,  0, 0, 0, 0},
        '{1, 0,  1024,  1024, 31, 31, 31, 31, 31, 31, 0, 0, 0},
        '{0, 0,  2047,     0,  1,  2,  4,  8, 16, 15, 0, 0, 0},
        '{0, 0,     0,  2047, 14, 15, 16,  1,  1,  1, 0, 0, 0}
    };

    // Register settings per random phase; extremes on every register.
    // The last phase is drawn at random.
    t_cfg_phase phases [PHASES] = '{
        '{63,     8,       20, 0},
        '{'h2A,   0,        1, 1},
        '{0,  65535, 16777215, 0},
        '{'h15,   3,       40, 0},
        '{63,    16,      100, 1},
        '{63,     0,        0, 0}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_tick      t;
        t_gate_word lit_word;
        t_cfg_phase ph;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        tick_bus    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_CHANNEL_ENABLE;
        i_cfg_wdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            t.bang   = plan[n].bang;
            t.rst    = plan[n].rst;
            t.width  = plan[n].width[LEVEL_W-1:0];
            t.swing  = plan[n].swing[LEVEL_W-1:0];
            t.div[0] = plan[n].d1[DIV_IN_W-1:0];
            t.div[1] = plan[n].d2[DIV_IN_W-1:0];
            t.div[2] = plan[n].d3[DIV_IN_W-1:0];
            t.div[3] = plan[n].d4[DIV_IN_W-1:0];
            t.div[4] = plan[n].d5[DIV_IN_W-1:0];
            t.div[5] = plan[n].d6[DIV_IN_W-1:0];
            lit_word.gates  = plan[n].lit_gates[GATE_W-1:0];
            lit_word.period = plan[n].lit_period[PERIOD_W-1:0];
            send_tick(t, plan[n].lit, lit_word);
        end
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            ph = phases[p];
            if (p == PHASES - 1) begin
                ph.enable    = $urandom_range(63);
                ph.swing_max = $urandom_range(20);
                ph.period    = $urandom_range(1, 200);
            end
            write_reg(CFG_CHANNEL_ENABLE, ph.enable);
            write_reg(CFG_SWING_MAX, ph.swing_max);
            write_reg(CFG_INIT_PERIOD, ph.period);
            if (ph.spare)
                write_reg(CFG_SPARE, $urandom_range(24'hFFFFFF));
            i_cfg_we = 1'b0;

            // fresh divisions per phase, small ones favored so gates fire often
            for (int c = 0; c < CH; c++)
                div_set[c] = ($urandom_range(1)) ? $urandom_range(1, 4)
                                                 : $urandom_range(1, 16);
            clk_pos = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_tick(make_tick(), 1'b0, '0);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, quiet stretches, and one long hold-off
    // so the block fills up and drops o_ready while ticks keep coming.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int r;
        bit steady;
        bit held;
        stall   = 0;
        steady  = 1'b0;
        held    = 1'b0;
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held    = 1'b1;
                i_ready = 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
                i_ready = 1'b1;
            end else if (stall > 0) begin
                i_ready = 1'b0;
                stall--;
            end else begin
                if ($urandom_range(99) < 2)
                    steady = ~steady;
                r = $urandom_range(99);
                if (steady || r < 55) begin
                    i_ready = 1'b1;
                end else begin
                    i_ready = 1'b0;
                    stall   = (r < 93) ? $urandom_range(2) : $urandom_range(15, 50);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check, field by field against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_beat
        t_gate_word want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (gate_queue.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: gates %h period %0d",
                         $time, o_gates, o_measured_period);
            end else begin
                want = gate_queue.pop_front();
                if (o_gates !== want.gates) begin
                    errors++;
                    $display("%0t: gates expected %h actual %h",
                             $time, want.gates, o_gates);
                end
                if (o_measured_period !== want.period) begin
                    errors++;
                    $display("%0t: measured_period expected %0d actual %0d",
                             $time, want.period, o_measured_period);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
